/* hdl/quaternion_rigid_point_transform_macros.svh */
// assertion helpers shared by the rigid transform block
`ifndef QUATERNION_RIGID_POINT_TRANSFORM_MACROS_SVH
`define QUATERNION_RIGID_POINT_TRANSFORM_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define QRPT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qrpt check failed");

// next-cycle implication, sampled on clk, off during reset
`define QRPT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qrpt check failed");

`endif

/* hdl/qrpt_pkg.sv */
package qrpt_pkg;

	// field widths
	localparam int QUAT_W     = 18;
	localparam int COORD_W    = 32;
	localparam int PROD_W     = 2 * QUAT_W;
	localparam int EXPR_W     = PROD_W + 1;
	localparam int MAT_SHIFT  = 8;
	localparam int MAT_W      = EXPR_W - MAT_SHIFT;
	localparam int MUL_W      = MAT_W + COORD_W;
	localparam int BASE_W     = COORD_W + 1;
	localparam int ACC_W      = 64;
	localparam int MAT_FRAC   = 24;
	localparam int RES_SHIFT  = MAT_FRAC - 1;
	localparam int RES_W      = ACC_W - RES_SHIFT;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_QUAT_W  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_X  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_Y  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_Z  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Z = 3'd6;

	// reset values
	localparam logic signed [QUAT_W-1:0] QUAT_ONE = 18'sd65536;

	typedef logic signed [QUAT_W-1:0]  quat_t;
	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [EXPR_W-1:0]  expr_t;
	typedef logic signed [MAT_W-1:0]   mat_t;
	typedef logic signed [MUL_W-1:0]   mul_t;
	typedef logic signed [BASE_W-1:0]  base_t;
	typedef logic signed [ACC_W-1:0]   acc_t;
	typedef logic signed [RES_W-1:0]   res_t;

	localparam coord_t COORD_MAX = 32'sh7fff_ffff;
	localparam coord_t COORD_MIN = 32'sh8000_0000;
	localparam acc_t   RES_HALF  = 64'sd1 <<< (RES_SHIFT - 1);
	localparam expr_t  MAT_HALF  = 37'sd1 <<< (MAT_SHIFT - 1);

	// sign-extend a product by one bit
	function automatic expr_t ext_prod(input prod_t p);
		return {p[PROD_W-1], p};
	endfunction

	// round half up to the matrix format
	function automatic mat_t round_mat(input expr_t e);
		expr_t t;
		t = e + MAT_HALF;
		return t[EXPR_W-1:MAT_SHIFT];
	endfunction

endpackage

/* hdl/quaternion_rigid_point_transform.sv */
// An accepted start passes the valid bits s1 to s6 before the done strobe carries its result.
// Throughput: one point per clock; busy is always low and start may be held high.
// The rotation matrix is rebuilt from the quaternion registers through the product and
// matrix registers, so a point may follow a configuration write in the very next cycle.
// Reset clears all valid bits and loads the identity quaternion and zero shift;
// results cannot be held off, done lasts one cycle per transaction.
`include "quaternion_rigid_point_transform_macros.svh"

module quaternion_rigid_point_transform
	import qrpt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  start,
	output logic                  busy,
	input  logic signed [31:0]    point_x,
	input  logic signed [31:0]    point_y,
	input  logic signed [31:0]    point_z,
	output logic                  done,
	output logic signed [31:0]    moved_x,
	output logic signed [31:0]    moved_y,
	output logic signed [31:0]    moved_z,
	output logic                  saturated
);

	quat_t  qw_q, qx_q, qy_q, qz_q;
	coord_t shift_q [3];

	prod_t  prod_q [9];
	mat_t   mat_q [9];

	logic   vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	coord_t pt_s1 [3];
	coord_t pt_s2 [3];
	base_t  base_s2 [3];
	base_t  base_s3 [3];
	mul_t   mul_s3 [9];
	acc_t   pair_s4 [3];
	acc_t   rest_s4 [3];
	acc_t   sum_s5 [3];
	coord_t res_s6 [3];
	logic   sat_s6;

	res_t   rnd [3];
	logic   ovf [3];
	coord_t clamp [3];

	logic   accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qw_q       <= QUAT_ONE;
			qx_q       <= '0;
			qy_q       <= '0;
			qz_q       <= '0;
			shift_q[0] <= '0;
			shift_q[1] <= '0;
			shift_q[2] <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_QUAT_W:  qw_q       <= cfg_wdata[QUAT_W-1:0];
				REG_QUAT_X:  qx_q       <= cfg_wdata[QUAT_W-1:0];
				REG_QUAT_Y:  qy_q       <= cfg_wdata[QUAT_W-1:0];
				REG_QUAT_Z:  qz_q       <= cfg_wdata[QUAT_W-1:0];
				REG_SHIFT_X: shift_q[0] <= cfg_wdata[COORD_W-1:0];
				REG_SHIFT_Y: shift_q[1] <= cfg_wdata[COORD_W-1:0];
				REG_SHIFT_Z: shift_q[2] <= cfg_wdata[COORD_W-1:0];
				default: ;
			endcase
		end
	end

	// quaternion products: wx wy wz xx xy xz yy yz zz
	always_ff @(posedge clk) begin
		prod_q[0] <= qw_q * qx_q;
		prod_q[1] <= qw_q * qy_q;
		prod_q[2] <= qw_q * qz_q;
		prod_q[3] <= qx_q * qx_q;
		prod_q[4] <= qx_q * qy_q;
		prod_q[5] <= qx_q * qz_q;
		prod_q[6] <= qy_q * qy_q;
		prod_q[7] <= qy_q * qz_q;
		prod_q[8] <= qz_q * qz_q;
	end

	// rotation matrix entries, rounded to 24 fraction bits
	always_ff @(posedge clk) begin
		mat_q[0] <= round_mat(-ext_prod(prod_q[6]) - ext_prod(prod_q[8]));
		mat_q[1] <= round_mat(ext_prod(prod_q[4]) - ext_prod(prod_q[2]));
		mat_q[2] <= round_mat(ext_prod(prod_q[1]) + ext_prod(prod_q[5]));
		mat_q[3] <= round_mat(ext_prod(prod_q[2]) + ext_prod(prod_q[4]));
		mat_q[4] <= round_mat(-ext_prod(prod_q[3]) - ext_prod(prod_q[8]));
		mat_q[5] <= round_mat(ext_prod(prod_q[7]) - ext_prod(prod_q[0]));
		mat_q[6] <= round_mat(ext_prod(prod_q[5]) - ext_prod(prod_q[1]));
		mat_q[7] <= round_mat(ext_prod(prod_q[0]) + ext_prod(prod_q[7]));
		mat_q[8] <= round_mat(-ext_prod(prod_q[3]) - ext_prod(prod_q[6]));
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// rounding and clamp of the row sums
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc_t t;
			t        = sum_s5[i] + RES_HALF;
			rnd[i]   = t[ACC_W-1:RES_SHIFT];
			ovf[i]   = (rnd[i][RES_W-1:COORD_W-1] != '0) && (rnd[i][RES_W-1:COORD_W-1] != '1);
			clamp[i] = ovf[i] ? (rnd[i][RES_W-1] ? COORD_MIN : COORD_MAX) : rnd[i][COORD_W-1:0];
		end
	end

	// data path stages
	always_ff @(posedge clk) begin
		// s1: capture the point
		if (accept) begin
			pt_s1[0] <= point_x;
			pt_s1[1] <= point_y;
			pt_s1[2] <= point_z;
		end
		// s2: point plus translation
		for (int i = 0; i < 3; i++) begin
			pt_s2[i]   <= pt_s1[i];
			base_s2[i] <= BASE_W'(pt_s1[i]) + BASE_W'(shift_q[i]);
		end
		// s3: matrix times point, one multiplier per entry
		for (int r = 0; r < 3; r++) begin
			base_s3[r] <= base_s2[r];
			for (int c = 0; c < 3; c++)
				mul_s3[r*3+c] <= mat_q[r*3+c] * pt_s2[c];
		end
		// s4: partial sums, offset carried at half weight
		for (int r = 0; r < 3; r++) begin
			pair_s4[r] <= ACC_W'(mul_s3[r*3]) + ACC_W'(mul_s3[r*3+1]);
			rest_s4[r] <= ACC_W'(mul_s3[r*3+2]) + (ACC_W'(base_s3[r]) <<< RES_SHIFT);
		end
		// s5: full row sum, half of the exact accumulator
		for (int r = 0; r < 3; r++)
			sum_s5[r] <= pair_s4[r] + rest_s4[r];
		// s6: rounded and saturated result
		for (int r = 0; r < 3; r++)
			res_s6[r] <= clamp[r];
		sat_s6 <= ovf[0] || ovf[1] || ovf[2];
	end

	assign done      = vld_s6;
	assign moved_x   = res_s6[0];
	assign moved_y   = res_s6[1];
	assign moved_z   = res_s6[2];
	assign saturated = sat_s6;

	// every accepted transaction comes out on done after the valid bits s1 to s6
	`QRPT_ASSERT_NOW(a_latency, accept, ##6 done)
	// a result always stems from a start carried through the valid bits s1 to s6
	`QRPT_ASSERT_NOW(a_no_spurious, done, $past(accept, 6))
	// a clamped result sits on a range limit
	`QRPT_ASSERT_NEXT(a_sat_limit, vld_s5 && (ovf[0] || ovf[1] || ovf[2]),
		moved_x == COORD_MAX || moved_x == COORD_MIN || moved_y == COORD_MAX ||
		moved_y == COORD_MIN || moved_z == COORD_MAX || moved_z == COORD_MIN)

endmodule

/* test/qrpt_checker.sv */
module qrpt_checker
	import qrpt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  start,
	input  logic                  busy,
	input  logic signed [31:0]    point_x,
	input  logic signed [31:0]    point_y,
	input  logic signed [31:0]    point_z,
	input  logic                  done,
	input  logic signed [31:0]    moved_x,
	input  logic signed [31:0]    moved_y,
	input  logic signed [31:0]    moved_z,
	input  logic                  saturated,
	output int                    mismatches,
	output int                    pending,
	output int                    points_taken,
	output int                    clamps_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PRINT_CAP = 100;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
		logic   sat;
	} moved_point_t;

	// local copy of the pose registers
	quat_t  pose_w, pose_x, pose_y, pose_z;
	coord_t pose_tx, pose_ty, pose_tz;

	// predicted transactions, oldest first
	moved_point_t moved_due[$];

	initial begin
		mismatches   = 0;
		pending      = 0;
		points_taken = 0;
		clamps_seen  = 0;
	end

	task automatic report_mismatch(input string msg);
		if (mismatches < PRINT_CAP)
			$display("%0t ns mismatch: %s", $time, msg);
		else if (mismatches == PRINT_CAP)
			$display("%0t ns further mismatches counted but not printed", $time);
		mismatches++;
	endtask

	// matrix entry to 24 fraction bits, half rounds up
	function automatic longint mat_entry(input longint e);
		return (e + 128) >>> 8;
	endfunction

	// drop the extra fraction bits and clamp to 32 bits; returns the clamp flag
	function automatic logic settle(input longint acc, output coord_t v);
		longint r;
		logic   hi, lo;
		r  = (acc + (longint'(1) <<< 23)) >>> 24;
		hi = r > longint'(COORD_MAX);
		lo = r < longint'(COORD_MIN);
		v  = hi ? COORD_MAX : (lo ? COORD_MIN : coord_t'(r));
		return hi | lo;
	endfunction

	// rotate by the stored quaternion, then add the stored translation
	function automatic moved_point_t rotate_and_shift(input coord_t px, input coord_t py,
		input coord_t pz);
		longint       w, x, y, z, a, b, c;
		longint       m [9];
		coord_t       vx, vy, vz;
		logic         sx, sy, sz;
		moved_point_t r;
		w = pose_w;
		x = pose_x;
		y = pose_y;
		z = pose_z;
		a = px;
		b = py;
		c = pz;
		m[0] = mat_entry(-(y * y) - z * z);
		m[1] = mat_entry(x * y - w * z);
		m[2] = mat_entry(w * y + x * z);
		m[3] = mat_entry(w * z + x * y);
		m[4] = mat_entry(-(x * x) - z * z);
		m[5] = mat_entry(y * z - w * x);
		m[6] = mat_entry(x * z - w * y);
		m[7] = mat_entry(w * x + y * z);
		m[8] = mat_entry(-(x * x) - y * y);
		sx = settle(2 * (m[0] * a + m[1] * b + m[2] * c) + ((a + longint'(pose_tx)) <<< 24), vx);
		sy = settle(2 * (m[3] * a + m[4] * b + m[5] * c) + ((b + longint'(pose_ty)) <<< 24), vy);
		sz = settle(2 * (m[6] * a + m[7] * b + m[8] * c) + ((c + longint'(pose_tz)) <<< 24), vz);
		r.x   = vx;
		r.y   = vy;
		r.z   = vz;
		r.sat = sx | sy | sz;
		return r;
	endfunction

	// watch config writes, accepted points and result strobes
	always @(posedge clk or negedge arst_n) begin
		moved_point_t want;
		if (!arst_n) begin
			pose_w  <= QUAT_ONE;
			pose_x  <= '0;
			pose_y  <= '0;
			pose_z  <= '0;
			pose_tx <= '0;
			pose_ty <= '0;
			pose_tz <= '0;
			moved_due.delete();
			pending <= 0;
		end else begin
			if (done) begin
				if (saturated === 1'b1)
					clamps_seen <= clamps_seen + 1;
				if (moved_due.size() == 0) begin
					report_mismatch("result strobe with no transaction outstanding");
				end else begin
					want = moved_due.pop_front();
					if (moved_x !== want.x)
						report_mismatch($sformatf("moved_x got %h want %h", moved_x, want.x));
					if (moved_y !== want.y)
						report_mismatch($sformatf("moved_y got %h want %h", moved_y, want.y));
					if (moved_z !== want.z)
						report_mismatch($sformatf("moved_z got %h want %h", moved_z, want.z));
					if (saturated !== want.sat)
						report_mismatch($sformatf("saturated got %b want %b", saturated,
							want.sat));
				end
			end
			if (start && !busy) begin
				moved_due.push_back(rotate_and_shift(point_x, point_y, point_z));
				points_taken <= points_taken + 1;
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_QUAT_W:  pose_w  <= quat_t'(cfg_wdata[QUAT_W-1:0]);
					REG_QUAT_X:  pose_x  <= quat_t'(cfg_wdata[QUAT_W-1:0]);
					REG_QUAT_Y:  pose_y  <= quat_t'(cfg_wdata[QUAT_W-1:0]);
					REG_QUAT_Z:  pose_z  <= quat_t'(cfg_wdata[QUAT_W-1:0]);
					REG_SHIFT_X: pose_tx <= coord_t'(cfg_wdata);
					REG_SHIFT_Y: pose_ty <= coord_t'(cfg_wdata);
					REG_SHIFT_Z: pose_tz <= coord_t'(cfg_wdata);
					default: ;
				endcase
			end
			pending <= moved_due.size();
		end
	end

endmodule

/* test/tb_quaternion_rigid_point_transform.sv */
module tb_quaternion_rigid_point_transform;
	timeunit 1ns;
	timeprecision 1ps;
	import qrpt_pkg::*;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int RANDOM_ITEMS = 1900;
	localparam int SETTLE_TIME  = 12;

	localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

	localparam quat_t QUAT_MIN    = 18'sh20000;
	localparam quat_t QUAT_MAX    = 18'sh1ffff;
	localparam quat_t QUAT_ZERO   = 18'sd0;
	localparam quat_t RIGHT_ANGLE = 18'sd46341;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  start     = 1'b0;
	logic signed [31:0]    point_x   = '0;
	logic signed [31:0]    point_y   = '0;
	logic signed [31:0]    point_z   = '0;
	logic                  busy;
	logic                  done;
	logic signed [31:0]    moved_x;
	logic signed [31:0]    moved_y;
	logic signed [31:0]    moved_z;
	logic                  saturated;

	int mismatches, pending, points_taken, clamps_seen;
	int cycle_count = 0;
	int settings    = 0;

	quaternion_rigid_point_transform u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.start     (start),
		.busy      (busy),
		.point_x   (point_x),
		.point_y   (point_y),
		.point_z   (point_z),
		.done      (done),
		.moved_x   (moved_x),
		.moved_y   (moved_y),
		.moved_z   (moved_z),
		.saturated (saturated)
	);

	qrpt_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.start        (start),
		.busy         (busy),
		.point_x      (point_x),
		.point_y      (point_y),
		.point_z      (point_z),
		.done         (done),
		.moved_x      (moved_x),
		.moved_y      (moved_y),
		.moved_z      (moved_z),
		.saturated    (saturated),
		.mismatches   (mismatches),
		.pending      (pending),
		.points_taken (points_taken),
		.clamps_seen  (clamps_seen)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timed out after %0d cycles with %0d transactions outstanding",
				cycle_count, pending);
			$display("status: fail");
			$finish;
		end
	end

	// one point transaction; busy is honoured even though it should stay low
	task automatic send_point(input coord_t x, input coord_t y, input coord_t z);
		start   <= 1'b1;
		point_x <= x;
		point_y <= y;
		point_z <= z;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// sender gap with noise on the point lines
	task automatic idle_cycles(input int n);
		repeat (n) begin
			start   <= 1'b0;
			point_x <= $urandom;
			point_y <= $urandom;
			point_z <= $urandom;
			@(posedge clk);
		end
	endtask

	// hold off until every predicted transaction has come back
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	// quaternion register value with junk in the unused upper bits
	function automatic logic [CFG_DATA_W-1:0] quat_word(input quat_t q);
		logic [CFG_DATA_W-1:0] d;
		d = $urandom;
		d[QUAT_W-1:0] = q;
		return d;
	endfunction

	// load a full pose once the block is idle
	task automatic set_pose(input quat_t w, input quat_t x, input quat_t y, input quat_t z,
		input coord_t sx, input coord_t sy, input coord_t sz);
		drain();
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_NONE, $urandom);
		write_reg(REG_QUAT_W, quat_word(w));
		write_reg(REG_QUAT_X, quat_word(x));
		write_reg(REG_QUAT_Y, quat_word(y));
		write_reg(REG_QUAT_Z, quat_word(z));
		write_reg(REG_SHIFT_X, sx);
		write_reg(REG_SHIFT_Y, sy);
		write_reg(REG_SHIFT_Z, sz);
		cfg_wr_en <= 1'b0;
		settings++;
	endtask

	function automatic coord_t extreme_coord();
		case ($urandom_range(0, 4))
			0: return COORD_MAX;
			1: return COORD_MIN;
			2: return '0;
			3: return -32'sd1;
			default: return 32'sd1;
		endcase
	endfunction

	// mostly modest coordinates, some full range, a few extremes
	function automatic coord_t pick_coord();
		int mode;
		mode = $urandom_range(0, 9);
		if (mode < 6)
			return coord_t'($urandom_range(0, 2097152) - 1048576);
		else if (mode < 9)
			return coord_t'($urandom);
		return extreme_coord();
	endfunction

	function automatic coord_t pick_shift();
		int mode;
		mode = $urandom_range(0, 9);
		if (mode < 5)
			return coord_t'($urandom_range(0, 8388608) - 4194304);
		else if (mode < 8)
			return coord_t'($urandom);
		return extreme_coord();
	endfunction

	function automatic quat_t extreme_quat();
		case ($urandom_range(0, 3))
			0: return QUAT_MIN;
			1: return QUAT_MAX;
			2: return QUAT_ZERO;
			default: return QUAT_ONE;
		endcase
	endfunction

	// unit quaternion, scaled one, fully random or extremes
	task automatic pick_pose(output quat_t w, output quat_t x, output quat_t y, output quat_t z);
		real c [4];
		real norm, gain;
		int  mode;
		mode = $urandom_range(0, 9);
		for (int k = 0; k < 4; k++)
			c[k] = real'($urandom_range(0, 2000)) - 1000.0;
		norm = $sqrt(c[0] * c[0] + c[1] * c[1] + c[2] * c[2] + c[3] * c[3]);
		if (norm < 1.0) begin
			c[0] = 1.0;
			norm = 1.0;
		end
		gain = 65536.0 / norm;
		if (mode >= 5)
			gain = gain * (0.25 + real'($urandom_range(0, 174)) / 100.0);
		if (mode < 7) begin
			w = quat_t'($rtoi(c[0] * gain));
			x = quat_t'($rtoi(c[1] * gain));
			y = quat_t'($rtoi(c[2] * gain));
			z = quat_t'($rtoi(c[3] * gain));
		end else if (mode < 9) begin
			w = quat_t'($urandom);
			x = quat_t'($urandom);
			y = quat_t'($urandom);
			z = quat_t'($urandom);
		end else begin
			w = extreme_quat();
			x = extreme_quat();
			y = extreme_quat();
			z = extreme_quat();
		end
	endtask

	// stimulus and verdict
	initial begin
		quat_t qw, qx, qy, qz;
		int    random_sent, phase_len, burst, gap;
		logic  steady;
		random_sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity pose straight out of reset
		send_point('0, '0, '0);
		send_point(COORD_MAX, COORD_MAX, COORD_MAX);
		send_point(COORD_MIN, COORD_MIN, COORD_MIN);
		send_point(32'sd1, -32'sd1, COORD_MAX);
		send_point(-32'sd1, COORD_MIN, '0);

		// most negative quaternion, largest shift: heavy clamping
		set_pose(QUAT_MIN, QUAT_MIN, QUAT_MIN, QUAT_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
		send_point('0, '0, '0);
		send_point(COORD_MAX, COORD_MIN, COORD_MAX);
		send_point(32'sd1, 32'sd1, 32'sd1);

		// write to the unused index, then largest quaternion with most negative shift
		drain();
		write_reg(REG_NONE, $urandom);
		set_pose(QUAT_MAX, QUAT_MAX, QUAT_MAX, QUAT_MAX, COORD_MIN, COORD_MIN, COORD_MIN);
		send_point('0, '0, '0);
		send_point(COORD_MIN, COORD_MAX, COORD_MIN);
		send_point(-32'sd1, 32'sd1, -32'sd1);

		// quarter turn about z with a small offset
		set_pose(RIGHT_ANGLE, QUAT_ZERO, QUAT_ZERO, RIGHT_ANGLE, 32'sd98304, -32'sd131072, '0);
		send_point(32'sd65536, '0, '0);
		send_point('0, 32'sd65536, '0);
		send_point(COORD_MIN, COORD_MAX, -32'sd1);

		// zero quaternion: the rotation term vanishes and the point is only shifted
		set_pose(QUAT_ZERO, QUAT_ZERO, QUAT_ZERO, QUAT_ZERO, COORD_MAX, COORD_MIN, '0);
		send_point(COORD_MAX, COORD_MIN, '0);
		send_point(32'sd1, -32'sd1, 32'sd5);

		// random poses, each followed by a burst-shaped stream of points
		while (random_sent < RANDOM_ITEMS) begin
			pick_pose(qw, qx, qy, qz);
			set_pose(qw, qx, qy, qz, pick_shift(), pick_shift(), pick_shift());
			phase_len = $urandom_range(80, 200);
			steady    = ($urandom_range(0, 3) == 0);
			burst     = 0;
			for (int i = 0; i < phase_len && random_sent < RANDOM_ITEMS; i++) begin
				if (!steady && burst == 0) begin
					burst = $urandom_range(1, 40);
					gap   = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
						: $urandom_range(0, 6);
					if ($urandom_range(0, 19) == 0)
						drain();
					else
						idle_cycles(gap);
				end
				send_point(pick_coord(), pick_coord(), pick_coord());
				if (burst > 0)
					burst--;
				random_sent++;
			end
		end

		// wait for the tail, then allow for anything stray
		drain();
		repeat (SETTLE_TIME) @(posedge clk);

		$display("covered %0d points under %0d poses, incl. extreme and unused-index writes",
			points_taken, settings);
		$display("%0d results clamped, %0d mismatches", clamps_seen, mismatches);
		if (mismatches == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
